@@ src/pfe_pkg.sv @@
// package for the postfix expression evaluator
// types, constants and fixed-point helpers shared by front and back end
`timescale 1ns / 1ps
package pfe_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int TOKEN_CHARS = 19;
	localparam int FRAC_BITS   = 32;
	localparam int MAX_FDIG    = 18;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int TC_W        = $clog2(TOKEN_CHARS + 1);
	localparam int Q_DEPTH     = 4;
	localparam int QP_W        = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [63:0] SIGN64 = 64'h8000000000000000;
	localparam logic [63:0] MAXPOS = 64'h7fffffffffffffff;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_UNDER = 3'd2,
		ST_OVER  = 3'd3,
		ST_DIV   = 3'd4
	} status_t;

	// operations handed from front to back end
	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_NONE
	} op_t;

	// one queue entry: operation, raw token fields, end-of-line mark
	typedef struct packed {
		op_t         op;
		logic        neg;
		logic [31:0] ipart;
		logic [63:0] frac;
		logic [4:0]  fdig;
		logic        last;
	} cmd_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_POP,
		BS_ARITH,
		BS_MUL1,
		BS_MUL2,
		BS_DIV,
		BS_DIVRND,
		BS_TOK,
		BS_TOKRND,
		BS_PUSH,
		BS_RESULT
	} bstate_t;

	// powers of ten for the fraction digit counts
	function automatic logic [63:0] pow10(input logic [4:0] n);
		logic [63:0] p;
		case (n)
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			5'd16:   p = 64'd10000000000000000;
			5'd17:   p = 64'd100000000000000000;
			5'd18:   p = 64'd1000000000000000000;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	function automatic logic [63:0] magnitude(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
		input logic ovf);
		if (neg)
			return (ovf || mag > SIGN64) ? SIGN64 : (~mag + 64'd1);
		return (ovf || mag > MAXPOS) ? MAXPOS : mag;
	endfunction

endpackage

@@ src/pfe_front.sv @@
// front end: classifies characters and collects number tokens
// depends on pfe_pkg; feeds commands into the queue
`timescale 1ns / 1ps
module pfe_front import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       line_end,
	input  logic       in_valid,
	output logic       in_ready,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	logic        pend_q, neg_q, point_q, stop_q, start_q, minus_q;
	logic [31:0] int_q;
	logic [63:0] frac_q;
	logic [4:0]  fdig_q;
	logic [TC_W-1:0] chars_q;

	// token registers after the character, and the command it emits
	logic        pend_d, neg_d, point_d, stop_d, start_d, minus_d;
	logic [31:0] int_d;
	logic [63:0] frac_d;
	logic [4:0]  fdig_d;
	logic [TC_W-1:0] chars_d;
	op_t         op_d;
	logic        tneg;
	logic [31:0] tint;
	logic [63:0] tfrac;
	logic [4:0]  tfdig;
	logic [35:0] t10;
	logic        hold_sub;

	// a deferred minus before a space or nul sends its subtract first,
	// the character itself is taken afterwards, once the queue is ready
	assign hold_sub = minus_q && (char_code == CH_SPACE || char_code == CH_NUL);
	assign in_ready = cmd_ready && !hold_sub;

	always_comb begin
		pend_d = pend_q; neg_d = neg_q; point_d = point_q; stop_d = stop_q;
		start_d = start_q; minus_d = minus_q; int_d = int_q; frac_d = frac_q;
		fdig_d = fdig_q; chars_d = chars_q; op_d = OP_NONE; t10 = '0;
		tneg = neg_q; tint = int_q; tfrac = frac_q; tfdig = fdig_q;
		// deferred minus joins the token ahead of the character
		if (minus_q && !hold_sub) begin
			minus_d = 1'b0;
			if (chars_d < TC_W'(TOKEN_CHARS)) begin
				chars_d = chars_d + 1'b1;
				pend_d = 1'b1;
				if (!stop_d && !start_d) begin
					start_d = 1'b1;
					neg_d = 1'b1;
				end else if (!stop_d) begin
					stop_d = 1'b1;
				end
			end
		end
		// the character proper
		if (char_code == CH_MINUS) begin
			if (line_end) op_d = OP_SUB;
			else minus_d = 1'b1;
		end else if (char_code == CH_PLUS) begin
			op_d = OP_ADD;
		end else if (char_code == CH_STAR) begin
			op_d = OP_MUL;
		end else if (char_code == CH_SLASH) begin
			op_d = OP_DIV;
		end else if (char_code == CH_SPACE) begin
			tneg = neg_d; tint = int_d; tfrac = frac_d; tfdig = fdig_d;
			op_d = pend_d ? OP_PUSH : OP_NONE;
			pend_d = 1'b0; neg_d = 1'b0; point_d = 1'b0; stop_d = 1'b0;
			start_d = 1'b0; int_d = '0; frac_d = '0; fdig_d = '0; chars_d = '0;
		end else if (chars_d < TC_W'(TOKEN_CHARS)) begin
			chars_d = chars_d + 1'b1;
			pend_d = 1'b1;
			// leading whitespace codes are skipped, the parse halts at a bad character
			if (!stop_d && !(!start_d && (char_code inside {[8'd9:8'd13]}))) begin
				start_d = 1'b1;
				if (char_code inside {[CH_ZERO:CH_NINE]}) begin
					if (point_d) begin
						if (fdig_d < 5'(MAX_FDIG)) begin
							frac_d = {frac_d[60:0], 3'b0} + {frac_d[62:0], 1'b0}
								+ {56'd0, char_code - CH_ZERO};
							fdig_d = fdig_d + 1'b1;
						end
					end else begin
						t10 = {4'd0, int_d} * 36'd10 + {28'd0, char_code - CH_ZERO};
						int_d = (t10 > 36'h0ffffffff) ? 32'hffffffff : t10[31:0];
					end
				end else if (char_code == CH_DOT && !point_d) begin
					point_d = 1'b1;
				end else begin
					stop_d = 1'b1;
				end
			end
		end
	end

	// command sent this cycle
	always_comb begin
		cmd.op    = hold_sub ? OP_SUB : op_d;
		cmd.neg   = tneg;
		cmd.ipart = tint;
		cmd.frac  = tfrac;
		cmd.fdig  = tfdig;
		cmd.last  = line_end && !hold_sub;
		cmd_valid = in_valid && (hold_sub || op_d != OP_NONE || line_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; neg_q <= 1'b0; point_q <= 1'b0; stop_q <= 1'b0;
			start_q <= 1'b0; minus_q <= 1'b0; int_q <= '0; frac_q <= '0;
			fdig_q <= '0; chars_q <= '0;
		end else if (in_valid && cmd_ready) begin
			if (hold_sub) begin
				minus_q <= 1'b0;
			end else if (line_end) begin
				pend_q <= 1'b0; neg_q <= 1'b0; point_q <= 1'b0; stop_q <= 1'b0;
				start_q <= 1'b0; minus_q <= 1'b0; int_q <= '0; frac_q <= '0;
				fdig_q <= '0; chars_q <= '0;
			end else begin
				pend_q <= pend_d; neg_q <= neg_d; point_q <= point_d; stop_q <= stop_d;
				start_q <= start_d; minus_q <= minus_d; int_q <= int_d;
				frac_q <= frac_d; fdig_q <= fdig_d; chars_q <= chars_d;
			end
		end
	end

endmodule

@@ src/pfe_queue.sv @@
// short command queue between front and back end
// depends on pfe_pkg for the command type
`timescale 1ns / 1ps
module pfe_queue import pfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output cmd_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);

	cmd_t mem_q [Q_DEPTH];
	logic [QP_W-1:0] wp_q, rp_q;
	logic [QP_W:0]   cnt_q;

	assign wr_ready = cnt_q != (QP_W+1)'(Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= wp_q + 1'b1;
			if (rd_valid && rd_ready) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QP_W+1)'(wr_valid && wr_ready) - (QP_W+1)'(rd_valid && rd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ src/pfe_back.sv @@
// back end: operand stack, fixed-point arithmetic, result register
// depends on pfe_pkg; consumes commands from the queue
`timescale 1ns / 1ps
module pfe_back import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	output logic [63:0] top_value,
	output logic [2:0]  status,
	output logic        out_valid,
	input  logic        out_ready
);

	logic [63:0] stk_q [STACK_DEPTH];
	logic [SP_W-1:0] cnt_q;
	logic [2:0] err_q;            // bit0 underflow, bit1 overflow, bit2 divide
	bstate_t st_q, st_d;
	cmd_t cmd_q;
	logic [63:0] l_q, r_q, res_q;
	logic [1:0] pops_q;
	logic [63:0] ma_q, mb_q, q_q, rem_q, p_q;
	logic [64:0] rw;
	logic [6:0] it_q;
	logic neg_q, ovf_q;
	logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
	logic [63:0] ll_q, lh_q, hl_q, hh_q;

	assign cmd_ready = st_q == BS_IDLE && !(out_valid && !out_ready);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BS_IDLE: if (cmd_valid && cmd_ready) begin
				case (cmd.op)
					OP_PUSH: st_d = BS_TOK;
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: st_d = BS_POP;
					default: st_d = cmd.last ? BS_RESULT : BS_IDLE;
				endcase
			end
			BS_POP: if (pops_q == 2'd1) st_d = BS_ARITH;
			BS_ARITH: case (cmd_q.op)
				OP_MUL: st_d = BS_MUL1;
				OP_DIV: st_d = (magnitude(r_q) == '0) ? BS_PUSH : BS_DIV;
				default: st_d = BS_PUSH;
			endcase
			BS_MUL1: st_d = BS_MUL2;
			BS_MUL2: st_d = BS_PUSH;
			BS_DIV: if (it_q == '0) st_d = BS_DIVRND;
			BS_DIVRND: st_d = BS_PUSH;
			BS_TOK: if (it_q == '0) st_d = BS_TOKRND;
			BS_TOKRND: st_d = BS_PUSH;
			BS_PUSH: st_d = cmd_q.last ? BS_RESULT : BS_IDLE;
			BS_RESULT: st_d = BS_IDLE;
			default: st_d = BS_IDLE;
		endcase
	end

	// partial products for the multiply
	assign pp_ll = ma_q[31:0] * mb_q[31:0];
	assign pp_lh = ma_q[31:0] * mb_q[63:32];
	assign pp_hl = ma_q[63:32] * mb_q[31:0];
	assign pp_hh = ma_q[63:32] * mb_q[63:32];

	// restoring division step
	logic dbit;
	always_comb begin
		dbit = (it_q >= 7'(FRAC_BITS)) ? ma_q[6'(it_q - 7'(FRAC_BITS))] : 1'b0;
		rw = {rem_q, dbit};
	end

	logic [63:0] mid, lo, hi, lo2, hi2;
	always_comb begin
		mid = {32'd0, ll_q[63:32]} + {32'd0, lh_q[31:0]} + {32'd0, hl_q[31:0]};
		lo  = {mid[31:0], ll_q[31:0]};
		hi  = hh_q + {32'd0, lh_q[63:32]} + {32'd0, hl_q[63:32]} + {32'd0, mid[63:32]};
		lo2 = lo + (64'd1 << (FRAC_BITS - 1));
		hi2 = hi + 64'(lo2 < lo);
	end

	logic [63:0] sum, dif;
	assign sum = l_q + r_q;
	assign dif = l_q - r_q;
	logic [64:0] trw;
	assign trw = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BS_IDLE; cnt_q <= '0; err_q <= '0; out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BS_RESULT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				BS_POP: begin
					if (cnt_q == '0) err_q[0] <= 1'b1;
					else cnt_q <= cnt_q - 1'b1;
				end
				BS_ARITH: if (cmd_q.op == OP_DIV && magnitude(r_q) == '0) err_q[2] <= 1'b1;
				BS_PUSH: begin
					if (cnt_q >= SP_W'(STACK_DEPTH)) err_q[1] <= 1'b1;
					else cnt_q <= cnt_q + 1'b1;
				end
				BS_RESULT: begin
					cnt_q <= '0; err_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			BS_IDLE: begin
				cmd_q <= cmd; pops_q <= 2'd0; r_q <= '0; l_q <= '0;
				ma_q <= {32'd0, cmd.ipart}; q_q <= '0;
				p_q <= pow10(cmd.fdig); it_q <= 7'(FRAC_BITS - 1);
				neg_q <= cmd.neg;
				// the fraction holds exactly fdig digits, so it is already below 10^fdig
				rem_q <= cmd.frac;
			end
			BS_POP: begin
				pops_q <= pops_q + 1'b1;
				if (pops_q == '0) r_q <= (cnt_q != '0) ? stk_q[IDX_W'(cnt_q - 1'b1)] : '0;
				else l_q <= (cnt_q != '0) ? stk_q[IDX_W'(cnt_q - 1'b1)] : '0;
			end
			BS_ARITH: begin
				ma_q <= magnitude(l_q); mb_q <= magnitude(r_q);
				neg_q <= l_q[63] ^ r_q[63]; ovf_q <= 1'b0;
				rem_q <= '0; q_q <= '0; it_q <= 7'(63 + FRAC_BITS);
				case (cmd_q.op)
					OP_ADD: res_q <= (!(l_q[63] ^ r_q[63]) && (sum[63] ^ l_q[63]))
						? (l_q[63] ? SIGN64 : MAXPOS) : sum;
					OP_SUB: res_q <= ((l_q[63] ^ r_q[63]) && (dif[63] ^ l_q[63]))
						? (l_q[63] ? SIGN64 : MAXPOS) : dif;
					default: res_q <= (magnitude(l_q) == '0) ? 64'd0
						: from_mag(l_q[63], 64'd0, 1'b1);
				endcase
			end
			BS_MUL1: begin
				ll_q <= pp_ll; lh_q <= pp_lh; hl_q <= pp_hl; hh_q <= pp_hh;
			end
			BS_MUL2: res_q <= ((hi2 >> FRAC_BITS) != '0) ? from_mag(neg_q, '0, 1'b1)
				: from_mag(neg_q, (hi2 << (64 - FRAC_BITS)) | (lo2 >> FRAC_BITS), 1'b0);
			BS_DIV: begin
				if (q_q[63]) ovf_q <= 1'b1;
				if (rw >= {1'b0, mb_q}) begin
					rem_q <= 64'(rw - {1'b0, mb_q});
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= rw[63:0];
					q_q <= {q_q[62:0], 1'b0};
				end
				if (it_q != '0) it_q <= it_q - 1'b1;
			end
			BS_DIVRND: begin
				if ({rem_q, 1'b0} >= {1'b0, mb_q}) begin
					res_q <= (q_q == '1) ? from_mag(neg_q, q_q, 1'b1)
						: from_mag(neg_q, q_q + 64'd1, ovf_q);
				end else res_q <= from_mag(neg_q, q_q, ovf_q);
			end
			BS_TOK: begin
				if (trw >= {1'b0, p_q}) begin
					rem_q <= 64'(trw - {1'b0, p_q});
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= trw[63:0];
					q_q <= {q_q[62:0], 1'b0};
				end
				if (it_q != '0) it_q <= it_q - 1'b1;
			end
			BS_TOKRND: begin
				if (ma_q >= (64'd1 << (63 - FRAC_BITS))) res_q <= from_mag(neg_q, '0, 1'b1);
				else res_q <= from_mag(neg_q, (ma_q << FRAC_BITS)
					+ ((cmd_q.fdig != '0) ? (q_q + 64'({rem_q, 1'b0} >= {1'b0, p_q})) : 64'd0),
					1'b0);
			end
			BS_PUSH: if (cnt_q < SP_W'(STACK_DEPTH)) stk_q[IDX_W'(cnt_q)] <= res_q;
			BS_RESULT: begin
				top_value <= (cnt_q != '0) ? stk_q[IDX_W'(cnt_q - 1'b1)] : 64'd0;
				status <= err_q[2] ? ST_DIV : err_q[1] ? ST_OVER : err_q[0] ? ST_UNDER
					: (cnt_q == '0) ? ST_EMPTY : ST_OK;
			end
			default: ;
		endcase
	end

	// result register is not overwritten while it waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SP_W'(STACK_DEPTH)) else $error("stack count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BS_RESULT |=> out_valid && cnt_q == '0) else $error("line not closed");

endmodule

@@ src/postfix_expression_evaluator.sv @@
// postfix expression evaluator, top level
// one character per input transfer; tdata = char_code, tlast = line_end
// a front end classifies characters and builds tokens, a four-entry queue
// decouples it from the back end that runs the operand stack
// a result transfer comes only on the last character of a line:
// tdata = top_value (64 bits, Q31.32), tuser = status (3 bits)
// the front end takes one character per cycle while the queue has room;
// a space or nul after a deferred minus waits while its subtract goes out
// the back end takes a new command only from idle: add and subtract pop,
// compute and push, multiply registers its partial products first, divide
// makes one quotient bit per cycle over 96 steps, a divide by zero skips
// the division, and a token push runs 32 fraction steps in the scaling
// loop; the back end's iterative units set the rate
// a stalled receiver holds the result register and the back end takes no
// command until it is gone; the front end fills the queue until it is full
// reset clears the stack count, token state and the queue
// depends on pfe_pkg, pfe_front, pfe_queue, pfe_back
`timescale 1ns / 1ps
module postfix_expression_evaluator import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // top_value[63:0]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast
);

	cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;

	pfe_front u_front (
		.clk, .arst_n, .char_code(s_tdata), .line_end(s_tlast),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	pfe_queue u_queue (
		.clk, .arst_n, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready)
	);

	pfe_back u_back (
		.clk, .arst_n, .cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.top_value(m_tdata), .status(m_tuser), .out_valid(m_tvalid),
		.out_ready(m_tready)
	);

	assign m_tlast = 1'b1;

endmodule
